// ===== hdl/fpsv_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsv_pkg
// Shared types and constants for the fact payload stream validator: status
// codes, the classified byte request passed from front to back, magic bytes.
// ----------------------------------------------------------------------------
package fpsv_pkg;

  localparam int unsigned MagicLength = 8;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned QueueDepth  = 2;

  // verdict codes
  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_TRUNCATED   = 4'd1,
    ST_BAD_MAGIC   = 4'd2,
    ST_BAD_KIND    = 4'd3,
    ST_NUL         = 4'd4,
    ST_TRAILING    = 4'd5,
    ST_PRED_EMPTY  = 4'd6,
    ST_PRED_START  = 4'd7,
    ST_PRED_CHAR   = 4'd8,
    ST_SCOPE_EMPTY = 4'd9,
    ST_SCOPE_CTRL  = 4'd10,
    ST_ARG_BAD     = 4'd11
  } status_e;

  // configuration register indexes
  typedef enum logic {
    CFG_INSERT_CODE  = 1'b0,
    CFG_RETRACT_CODE = 1'b1
  } cfg_index_e;

  // one classified payload byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       in_magic;
    logic       magic_ok;
    logic       kind_insert;
    logic       kind_retract;
    logic       is_nul;
    logic       is_ctrl;
    logic       pred_start_ok;
    logic       pred_char_ok;
  } token_t;

  // expected magic byte at a header position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h57;
      3'd1:    b = 8'h59;
      3'd2:    b = 8'h52;
      3'd3:    b = 8'h45;
      3'd4:    b = 8'h46;
      3'd5:    b = 8'h4D;
      3'd6:    b = 8'h50;
      3'd7:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/fact_payload_stream_validator_unit.sv =====
// The final byte is written into the queue, then parsed into the result register
// before the verdict shows on out_valid_o; bytes already in the queue are parsed first.
// Throughput: 1 payload byte per cycle; the parser retires one byte each cycle unless
// stalled, and a two-entry queue separates it from the byte classifier.
// A pending verdict not yet taken stalls the parser; bytes queue until it is full.
// Reset (rst_ni low, asynchronous) returns the parser to the header and empties the queue.
// ----------------------------------------------------------------------------
// fact_payload_stream_validator_unit
// Streaming validator for fact mutation payloads: one verdict per payload.
// Reset also drops any pending verdict and sets insert code 0, retract code 1.
// ----------------------------------------------------------------------------
module fact_payload_stream_validator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic        kind_is_retract_o,
  output logic [31:0] arg_count_o
);
  import fpsv_pkg::*;

  token_t front_tok;
  token_t queue_tok;
  logic   push;
  logic   full;
  logic   pop;
  logic   queue_valid;

  // classifier
  fpsv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .final_byte_i   (final_byte_i),
    .queue_full_i   (full),
    .push_o         (push),
    .token_o        (front_tok)
  );

  // decoupling queue
  fpsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (front_tok),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .token_o (queue_tok)
  );

  // parser and result register
  fpsv_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tok_valid_i       (queue_valid),
    .tok_i             (queue_tok),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .kind_is_retract_o (kind_is_retract_o),
    .arg_count_o       (arg_count_o)
  );

endmodule

// ===== hdl/fpsv_front.sv =====
// ----------------------------------------------------------------------------
// fpsv_front
// Accepts payload bytes, tracks the header position and classifies each
// byte (magic match, kind match, character classes) for the back end.
// ----------------------------------------------------------------------------
module fpsv_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      payload_byte_i,
  input  logic            final_byte_i,
  input  logic            queue_full_i,
  output logic            push_o,
  output fpsv_pkg::token_t token_o
);
  import fpsv_pkg::*;

  logic [7:0]          insert_code_q;
  logic [7:0]          retract_code_q;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic                is_lower;
  logic                is_alnum;
  logic [7:0]          b;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      insert_code_q  <= 8'd0;
      retract_code_q <= 8'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_INSERT_CODE) begin
        insert_code_q <= cfg_data_i;
      end else begin
        retract_code_q <= cfg_data_i;
      end
    end
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // header position, saturates once past the kind byte
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (final_byte_i) begin
        pos_d = '0;
      end else if (pos_q <= PosWidth'(MagicLength)) begin
        pos_d = pos_q + PosWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // byte classification
  assign b        = payload_byte_i;
  assign is_lower = (b >= 8'h61) && (b <= 8'h7A);
  assign is_alnum = is_lower || ((b >= 8'h41) && (b <= 8'h5A)) ||
                    ((b >= 8'h30) && (b <= 8'h39));

  always_comb begin
    token_o               = '0;
    token_o.data          = b;
    token_o.last          = final_byte_i;
    token_o.in_magic      = pos_q < PosWidth'(MagicLength);
    token_o.magic_ok      = (b == magic_byte(pos_q[2:0]));
    token_o.kind_insert   = (b == insert_code_q);
    token_o.kind_retract  = (b == retract_code_q);
    token_o.is_nul        = (b == 8'h00);
    token_o.is_ctrl       = (b < 8'h20) || (b == 8'h7F);
    token_o.pred_start_ok = is_lower || (b == 8'h5F);
    token_o.pred_char_ok  = is_alnum || (b == 8'h5F);
  end

endmodule

// ===== hdl/fpsv_queue.sv =====
// ----------------------------------------------------------------------------
// fpsv_queue
// Two-entry queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module fpsv_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fpsv_pkg::token_t token_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output fpsv_pkg::token_t token_o
);
  import fpsv_pkg::*;

  token_t     mem_q [QueueDepth];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(QueueDepth));
  assign valid_o = (count_q != 2'd0);
  assign token_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/fpsv_back.sv =====
// ----------------------------------------------------------------------------
// fpsv_back
// Parser: walks header, length fields and strings one byte a cycle unless
// stalled, records structural and content faults, registers the verdict.
// ----------------------------------------------------------------------------
module fpsv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  fpsv_pkg::token_t tok_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       status_o,
  output logic             kind_is_retract_o,
  output logic [31:0]      arg_count_o
);
  import fpsv_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LENGTH = 5'b00010,
    PH_STRING = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    STR_PREDICATE = 2'd0,
    STR_SCOPE     = 2'd1,
    STR_COUNT     = 2'd2,
    STR_ARGUMENT  = 2'd3
  } string_e;

  phase_e      phase_q, phase_d;
  logic        mismatch_q, mismatch_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] left_q, left_d;
  string_e     cur_q, cur_d;
  logic        first_q, first_d;
  logic        nul_q, nul_d;
  logic [31:0] args_q, args_d;
  logic [31:0] count_q, count_d;
  logic        kind_q, kind_d;
  status_e     serr_q, serr_d;
  status_e     cerr_q, cerr_d;

  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic        out_kind_q, out_kind_d;
  logic [31:0] out_count_q, out_count_d;

  logic        str_done;
  logic        nul_now;
  status_e     cnote;
  status_e     sfail;
  logic        do_fail;
  logic [31:0] len;
  status_e     verdict;

  assign pop_o = tok_valid_i && (!out_valid_q || out_ready_i);

  // parse step
  always_comb begin
    phase_d      = phase_q;
    mismatch_d   = mismatch_q;
    acc_d        = acc_q;
    idx_d        = idx_q;
    left_d       = left_q;
    cur_d        = cur_q;
    first_d      = first_q;
    nul_d        = nul_q;
    args_d       = args_q;
    count_d      = count_q;
    kind_d       = kind_q;
    serr_d       = serr_q;
    cerr_d       = cerr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_kind_d   = out_kind_q;
    out_count_d  = out_count_q;
    str_done     = 1'b0;
    nul_now      = 1'b0;
    cnote        = ST_OK;
    sfail        = ST_OK;
    do_fail      = 1'b0;
    len          = {tok_i.data, acc_q[23:0]};
    verdict      = ST_OK;

    if (pop_o) begin
      case (phase_q)
        PH_HEADER: begin
          if (tok_i.in_magic) begin
            if (!tok_i.magic_ok) begin
              mismatch_d = 1'b1;
            end
          end else begin
            if (mismatch_q) begin
              do_fail = 1'b1;
              sfail   = ST_BAD_MAGIC;
            end else if (tok_i.kind_insert) begin
              kind_d  = 1'b0;
              phase_d = PH_LENGTH;
            end else if (tok_i.kind_retract) begin
              kind_d  = 1'b1;
              phase_d = PH_LENGTH;
            end else begin
              do_fail = 1'b1;
              sfail   = ST_BAD_KIND;
            end
            idx_d = 2'd0;
            acc_d = '0;
          end
        end
        PH_LENGTH: begin
          if (idx_q == 2'd3) begin
            idx_d = 2'd0;
            if (cur_q == STR_COUNT) begin
              count_d = len;
              args_d  = len;
              cur_d   = STR_ARGUMENT;
              phase_d = (len == 32'd0) ? PH_DONE : PH_LENGTH;
              acc_d   = '0;
            end else begin
              left_d  = len;
              first_d = 1'b1;
              nul_d   = 1'b0;
              if (len == 32'd0) begin
                case (cur_q)
                  STR_PREDICATE: cnote = ST_PRED_EMPTY;
                  STR_SCOPE:     cnote = ST_SCOPE_EMPTY;
                  default:       cnote = ST_ARG_BAD;
                endcase
                str_done = 1'b1;
              end else begin
                phase_d = PH_STRING;
              end
            end
          end else begin
            acc_d[{idx_q, 3'b000} +: 8] = tok_i.data;
            idx_d = idx_q + 2'd1;
          end
        end
        PH_STRING: begin
          nul_now = nul_q || tok_i.is_nul;
          nul_d   = nul_now;
          if (cur_q == STR_PREDICATE) begin
            if (first_q) begin
              if (!tok_i.pred_start_ok) begin
                cnote = ST_PRED_START;
              end
            end else if (!tok_i.pred_char_ok) begin
              cnote = ST_PRED_CHAR;
            end
          end else if (tok_i.is_ctrl) begin
            cnote = (cur_q == STR_SCOPE) ? ST_SCOPE_CTRL : ST_ARG_BAD;
          end
          first_d  = 1'b0;
          left_d   = left_q - 32'd1;
          str_done = (left_d == 32'd0);
        end
        PH_DONE: begin
          do_fail = 1'b1;
          sfail   = ST_TRAILING;
        end
        default: begin
        end
      endcase

      // end of a string: nul fault, else next length field or done
      if (str_done) begin
        if (nul_now) begin
          do_fail = 1'b1;
          sfail   = ST_NUL;
        end else begin
          phase_d = PH_LENGTH;
          idx_d   = 2'd0;
          acc_d   = '0;
          case (cur_q)
            STR_PREDICATE: cur_d = STR_SCOPE;
            STR_SCOPE:     cur_d = STR_COUNT;
            default: begin
              args_d = args_q - 32'd1;
              if (args_d == 32'd0) begin
                phase_d = PH_DONE;
              end
            end
          endcase
        end
      end

      // first fault of each class wins
      if (cnote != ST_OK && cerr_q == ST_OK) begin
        cerr_d = cnote;
      end
      if (do_fail) begin
        phase_d = PH_STOP;
        if (serr_q == ST_OK) begin
          serr_d = sfail;
        end
      end

      // verdict on the last byte, then back to reset state
      if (tok_i.last) begin
        if (phase_d == PH_HEADER) begin
          verdict = ST_TRUNCATED;
        end else if (serr_d != ST_OK) begin
          verdict = serr_d;
        end else if (phase_d != PH_DONE) begin
          verdict = ST_TRUNCATED;
        end else begin
          verdict = cerr_d;
        end
        out_valid_d  = 1'b1;
        out_status_d = verdict;
        out_kind_d   = (verdict == ST_OK) && kind_d;
        out_count_d  = (verdict == ST_OK) ? count_d : 32'd0;
        phase_d      = PH_HEADER;
        mismatch_d   = 1'b0;
        acc_d        = '0;
        idx_d        = 2'd0;
        left_d       = '0;
        cur_d        = STR_PREDICATE;
        first_d      = 1'b1;
        nul_d        = 1'b0;
        args_d       = '0;
        count_d      = '0;
        kind_d       = 1'b0;
        serr_d       = ST_OK;
        cerr_d       = ST_OK;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      mismatch_q  <= 1'b0;
      acc_q       <= '0;
      idx_q       <= 2'd0;
      left_q      <= '0;
      cur_q       <= STR_PREDICATE;
      first_q     <= 1'b1;
      nul_q       <= 1'b0;
      args_q      <= '0;
      count_q     <= '0;
      kind_q      <= 1'b0;
      serr_q      <= ST_OK;
      cerr_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mismatch_q  <= mismatch_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      left_q      <= left_d;
      cur_q       <= cur_d;
      first_q     <= first_d;
      nul_q       <= nul_d;
      args_q      <= args_d;
      count_q     <= count_d;
      kind_q      <= kind_d;
      serr_q      <= serr_d;
      cerr_q      <= cerr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_kind_q   <= out_kind_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign kind_is_retract_o = out_kind_q;
  assign arg_count_o       = out_count_q;

endmodule

// ===== hdl/fpsv_checker.sv =====
// ----------------------------------------------------------------------------
// fpsv_checker
// Port-level assertions for the validator, bound to the top level.
// ----------------------------------------------------------------------------
module fpsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  status_o,
  input logic        kind_is_retract_o,
  input logic [31:0] arg_count_o
);
  import fpsv_pkg::*;

  // a stalled verdict stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("verdict dropped while stalled");

  // a stalled verdict keeps its status
  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o))
    else $error("verdict changed while stalled");

  // failing verdicts carry no kind or count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      !kind_is_retract_o && (arg_count_o == 32'd0))
    else $error("fields set on failing verdict");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_ARG_BAD)
    else $error("undefined status code");

endmodule

bind fact_payload_stream_validator_unit fpsv_checker u_fpsv_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Byte-stream test of the fact payload stream validator. Directed payloads
// cover the header, length, string and trailing rules; random payloads,
// mostly well formed with random faults, run under several kind codes.
// A scoreboard class tracks the parse and checks every verdict in order.
// ----------------------------------------------------------------------------
import fpsv_pkg::*;

typedef enum {P_HEADER, P_LENGTH, P_STRING, P_DONE, P_STOP} parse_phase_e;
typedef enum {F_PREDICATE, F_SCOPE, F_COUNT, F_ARGUMENT} field_e;

class verdict_scoreboard;
  typedef struct packed {
    status_e     status;
    logic        retract;
    logic [31:0] count;
  } verdict_t;

  bit [7:0]  insert_code  = 8'h00;
  bit [7:0]  retract_code = 8'h01;
  // header magic, first byte in the low bits
  bit [63:0] magic_word   = 64'h3150_4D46_4552_5957;

  parse_phase_e phase;
  field_e       cur_field;
  int unsigned  hdr_pos;
  bit           magic_bad;
  bit [31:0]    len_acc;
  int unsigned  len_idx;
  bit [31:0]    chars_left;
  bit           first_char;
  bit           nul_in_field;
  bit [31:0]    args_left;
  bit [31:0]    count_seen;
  bit           kind_retract;
  status_e      structure_err;
  status_e      content_err;

  verdict_t verdict_q[$];
  int       failures;

  function new();
    failures = 0;
    restart();
  endfunction

  // parse state back to the start of a payload
  function void restart();
    phase         = P_HEADER;
    cur_field     = F_PREDICATE;
    hdr_pos       = 0;
    magic_bad     = 1'b0;
    len_acc       = '0;
    len_idx       = 0;
    chars_left    = '0;
    first_char    = 1'b1;
    nul_in_field  = 1'b0;
    args_left     = '0;
    count_seen    = '0;
    kind_retract  = 1'b0;
    structure_err = ST_OK;
    content_err   = ST_OK;
  endfunction

  // only the first content fault in stream order is kept
  function void flag_content(status_e s);
    if (content_err == ST_OK) content_err = s;
  endfunction

  function void flag_structure(status_e s);
    if (structure_err == ST_OK) structure_err = s;
    phase = P_STOP;
  endfunction

  // string fully read: nul check, then on to the next length field or done
  function void close_field();
    if (nul_in_field) begin
      flag_structure(ST_NUL);
      return;
    end
    phase   = P_LENGTH;
    len_idx = 0;
    len_acc = '0;
    case (cur_field)
      F_PREDICATE: cur_field = F_SCOPE;
      F_SCOPE:     cur_field = F_COUNT;
      default: begin
        args_left = args_left - 1;
        if (args_left == 0) phase = P_DONE;
      end
    endcase
  endfunction

  function void close_length(bit [31:0] len);
    if (cur_field == F_COUNT) begin
      count_seen = len;
      args_left  = len;
      cur_field  = F_ARGUMENT;
      phase      = (len == 0) ? P_DONE : P_LENGTH;
      len_idx    = 0;
      len_acc    = '0;
      return;
    end
    chars_left   = len;
    first_char   = 1'b1;
    nul_in_field = 1'b0;
    if (len == 0) begin
      case (cur_field)
        F_PREDICATE: flag_content(ST_PRED_EMPTY);
        F_SCOPE:     flag_content(ST_SCOPE_EMPTY);
        default:     flag_content(ST_ARG_BAD);
      endcase
      close_field();
    end else begin
      phase = P_STRING;
    end
  endfunction

  function void consume(bit [7:0] b);
    bit lower;
    bit alnum;
    lower = (b >= 8'h61) && (b <= 8'h7A);
    alnum = lower || ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h30) && (b <= 8'h39));
    case (phase)
      P_HEADER: begin
        if (hdr_pos < 8) begin
          if (b != magic_word[8*hdr_pos +: 8]) magic_bad = 1'b1;
          hdr_pos++;
        end else begin
          hdr_pos++;
          // equal codes resolve to insert
          if (magic_bad) begin
            flag_structure(ST_BAD_MAGIC);
          end else if (b == insert_code) begin
            kind_retract = 1'b0;
            phase        = P_LENGTH;
          end else if (b == retract_code) begin
            kind_retract = 1'b1;
            phase        = P_LENGTH;
          end else begin
            flag_structure(ST_BAD_KIND);
          end
          len_idx = 0;
          len_acc = '0;
        end
      end
      P_LENGTH: begin
        // little-endian length
        len_acc[8*len_idx +: 8] = b;
        if (len_idx == 3) begin
          len_idx = 0;
          close_length(len_acc);
        end else begin
          len_idx++;
        end
      end
      P_STRING: begin
        if (b == 8'h00) nul_in_field = 1'b1;
        if (cur_field == F_PREDICATE) begin
          if (first_char) begin
            if (!(lower || b == 8'h5F)) flag_content(ST_PRED_START);
          end else if (!(alnum || b == 8'h5F)) begin
            flag_content(ST_PRED_CHAR);
          end
        end else if (b < 8'h20 || b == 8'h7F) begin
          flag_content(cur_field == F_SCOPE ? ST_SCOPE_CTRL : ST_ARG_BAD);
        end
        first_char = 1'b0;
        chars_left = chars_left - 1;
        if (chars_left == 0) close_field();
      end
      P_DONE: flag_structure(ST_TRAILING);
      default: ;
    endcase
  endfunction

  // accepted byte request; a final byte yields one expected verdict
  function void note_request(bit [7:0] b, bit fin);
    verdict_t want;
    status_e  st;
    consume(b);
    if (!fin) return;
    if (phase == P_HEADER) st = ST_TRUNCATED;
    else if (structure_err != ST_OK) st = structure_err;
    else if (phase != P_DONE) st = ST_TRUNCATED;
    else st = content_err;
    want.status  = st;
    want.retract = (st == ST_OK) && kind_retract;
    want.count   = (st == ST_OK) ? count_seen : '0;
    verdict_q.push_back(want);
    restart();
  endfunction

  function void check_verdict(logic [3:0] status, logic retract, logic [31:0] count);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected verdict: status %0d retract %0b count %0d",
                 status, retract, count);
      return;
    end
    want = verdict_q.pop_front();
    if (status !== want.status || retract !== want.retract || count !== want.count) begin
      failures++;
      if (failures <= 10)
        $display({"verdict mismatch: expected status %0d retract %0b count %0d,",
                  " got status %0d retract %0b count %0d"},
                 want.status, want.retract, want.count, status, retract, count);
    end
  endfunction
endclass

module testbench;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 300;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_we         = 1'b0;
  cfg_index_e  cfg_index      = CFG_INSERT_CODE;
  logic [7:0]  cfg_data       = 8'h00;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  payload_byte   = 8'h00;
  logic        final_byte     = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [3:0]  status;
  logic        kind_is_retract;
  logic [31:0] arg_count;

  verdict_scoreboard sb;
  bit [7:0]          frame[$];
  bit                no_idle         = 1'b0;
  bit                hold_off_req    = 1'b0;
  bit                hold_off_done   = 1'b0;
  int unsigned       quiet_cycles    = 0;

  fact_payload_stream_validator_unit DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .payload_byte_i    (payload_byte),
    .final_byte_i      (final_byte),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .kind_is_retract_o (kind_is_retract),
    .arg_count_o       (arg_count)
  );

  always #5 clk = ~clk;

  // monitor both handshakes
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(payload_byte, final_byte);
    if (rst_n && out_valid && out_ready)
      sb.check_verdict(status, kind_is_retract, arg_count);
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("[fact_payload_stream_validator_unit] ERROR");
      $finish;
    end
  end

  // verdict receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // payload building

  function automatic void put_word(bit [31:0] v);
    for (int i = 0; i < 4; i++) frame.push_back(v[8*i +: 8]);
  endfunction

  function automatic void open_frame(bit [7:0] kind);
    frame.delete();
    for (int i = 0; i < 8; i++) frame.push_back(sb.magic_word[8*i +: 8]);
    frame.push_back(kind);
  endfunction

  function automatic void put_text(string s);
    put_word(s.len());
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endfunction

  function automatic void build_fact(bit [7:0] kind, string pred, string scope,
                                     bit [31:0] args);
    open_frame(kind);
    put_text(pred);
    put_text(scope);
    put_word(args);
  endfunction

  // mostly short strings, sometimes empty or long
  function automatic int unsigned text_len();
    if ($urandom_range(15) == 0) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(20, 40);
    return $urandom_range(1, 6);
  endfunction

  // well-formed characters with an occasional byte of any value
  function automatic void put_random_text(bit is_pred, int unsigned len);
    bit [7:0] c;
    put_word(len);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        c = 8'($urandom_range(255));
      end else if (is_pred && i == 0) begin
        c = ($urandom_range(3) == 0) ? 8'h5F : 8'(8'h61 + $urandom_range(25));
      end else if (is_pred) begin
        case ($urandom_range(3))
          0:       c = 8'h5F;
          1:       c = 8'(8'h30 + $urandom_range(9));
          2:       c = 8'(8'h41 + $urandom_range(25));
          default: c = 8'(8'h61 + $urandom_range(25));
        endcase
      end else begin
        c = ($urandom_range(4) == 0) ? 8'(8'h80 + $urandom_range(127))
                                     : 8'(8'h20 + $urandom_range(94));
      end
      frame.push_back(c);
    end
  endfunction

  // sender: random idles, valid held until the request is taken
  task automatic send_frame();
    foreach (frame[i]) begin
      while (!no_idle && $urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      payload_byte <= frame[i];
      final_byte   <= (i == frame.size() - 1);
      do @(posedge clk); while (!in_ready);
    end
  endtask

  // sender pause until every verdict is back
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input bit [7:0] ins, input bit [7:0] ret);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INSERT_CODE;
    cfg_data  <= ins;
    @(posedge clk);
    cfg_index <= CFG_RETRACT_CODE;
    cfg_data  <= ret;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.insert_code  = ins;
    sb.retract_code = ret;
  endtask

  // random payloads, mostly well formed, about 30% with one fault
  task automatic run_random_phase(input bit calm);
    int unsigned bytes_sent;
    int unsigned args;
    int unsigned cut;
    bytes_sent = 0;
    no_idle    = calm;
    while (bytes_sent < 50) begin
      open_frame($urandom_range(1) ? sb.retract_code : sb.insert_code);
      put_random_text(1'b1, text_len());
      put_random_text(1'b0, text_len());
      args = $urandom_range(3);
      put_word(args);
      for (int unsigned i = 0; i < args; i++) put_random_text(1'b0, text_len());
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(4))
          0: frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
          1: begin
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut) void'(frame.pop_back());
          end
          2: repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(255)));
          // huge predicate length
          3: frame[12] = 8'($urandom_range(1, 255));
          default: begin
            frame.delete();
            repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom_range(255)));
          end
        endcase
      end
      send_frame();
      bytes_sent += frame.size();
      if ($urandom_range(9) == 0) wait_for_verdicts();
    end
    wait_for_verdicts();
    no_idle = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clean insert, no arguments
    build_fact(8'h00, "fact", "world", 0);
    send_frame();
    // clean retract, two arguments, high bytes in scope and argument
    build_fact(8'h01, "_p9Z", "s\377\200~", 2);
    put_text("x");
    put_text(" \377");
    send_frame();
    // one-byte payload
    frame.delete();
    frame.push_back(8'h00);
    send_frame();
    // eight bytes: short wins over a wrong magic
    frame.delete();
    repeat (8) frame.push_back(8'hFF);
    send_frame();
    // wrong magic on nine bytes
    open_frame(8'h00);
    frame[0] = 8'h00;
    send_frame();
    // wrong magic wins over a bad kind, rest ignored
    build_fact(8'h07, "fact", "s", 0);
    frame[7] = 8'h30;
    send_frame();
    // unknown kind
    open_frame(8'h02);
    send_frame();
    // payload ends on the kind byte
    open_frame(8'h01);
    send_frame();
    // complete predicate holding a nul
    build_fact(8'h00, "ab", "s", 0);
    frame[14] = 8'h00;
    send_frame();
    // nul inside a predicate that is cut short
    open_frame(8'h00);
    put_word(4);
    frame.push_back(8'h61);
    frame.push_back(8'h00);
    send_frame();
    // trailing byte after a zero count
    build_fact(8'h00, "p", "s", 0);
    frame.push_back(8'h00);
    send_frame();
    // trailing after the last argument wins over a bad predicate start
    build_fact(8'h01, "9x", "s", 1);
    put_text("a");
    frame.push_back(8'h41);
    send_frame();
    // predicate faults
    build_fact(8'h00, "", "s", 0);
    send_frame();
    build_fact(8'h00, "Abc", "s", 0);
    send_frame();
    build_fact(8'h00, "ab-c", "s", 0);
    send_frame();
    build_fact(8'h00, "a\200", "s", 0);
    send_frame();
    // scope faults
    build_fact(8'h00, "p", "", 0);
    send_frame();
    build_fact(8'h00, "p", "x\177", 0);
    send_frame();
    build_fact(8'h00, "p", "\037", 0);
    send_frame();
    // argument faults
    build_fact(8'h01, "p", "s", 1);
    put_text("");
    send_frame();
    build_fact(8'h01, "p", "s", 1);
    put_text("a\001");
    send_frame();
    // first content fault in stream order wins
    build_fact(8'h00, "Ab", "\177", 0);
    send_frame();
    // all-ones argument count, payload stops after it
    build_fact(8'h00, "p", "s", 32'hFFFF_FFFF);
    send_frame();
    wait_for_verdicts();

    // extreme codes; the random phase runs with no idling
    write_config(8'hFF, 8'h00);
    build_fact(8'hFF, "fact", "s", 0);
    send_frame();
    build_fact(8'h00, "fact", "s", 0);
    send_frame();
    open_frame(8'h01);
    send_frame();
    run_random_phase(1'b1);

    // equal codes count as insert; long receiver hold-off
    write_config(8'h5A, 8'h5A);
    build_fact(8'h5A, "fact", "s", 1);
    put_text("arg");
    send_frame();
    hold_off_req = 1'b1;
    run_random_phase(1'b0);

    // random codes
    repeat (2) begin
      write_config(8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random_phase(1'b0);
    end

    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.verdict_q.size() == 0) begin
      $display("[fact_payload_stream_validator_unit] OK");
    end else begin
      $display("[fact_payload_stream_validator_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== fact_payload_stream_validator_unit.f =====
hdl/fpsv_pkg.sv
hdl/fpsv_front.sv
hdl/fpsv_queue.sv
hdl/fpsv_back.sv
hdl/fact_payload_stream_validator_unit.sv
hdl/fpsv_checker.sv
tb/testbench.sv
